FILE: sv/epms_pkg.sv
// Package for the streaming exact pattern matcher.
// Holds sizes, operation codes, the result word type and the length clamp.
// No dependencies; every other file imports it.
`default_nettype none

package epms_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int POSITION_BITS = 32;

    localparam int OP_W          = 2;
    localparam int SYMBOL_W      = 8;
    localparam int CFG_LEN_W     = 5;
    localparam int MATCH_START_W = 32;

    localparam int USED_W    = $clog2(MAX_PATTERN + 1);
    localparam int FILL_W    = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PAT_BITS  = MAX_PATTERN * SYMBOL_W;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [CFG_LEN_W-1:0] LEN_RESET = 5'd1;

    typedef struct packed {
        logic                     match;
        logic [MATCH_START_W-1:0] match_start;
    } t_result;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    // Length actually compared: zero counts as one, large values saturate.
    function automatic logic [USED_W-1:0] f_used_len(input logic [CFG_LEN_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0) begin
            return USED_W'(1);
        end else if (w > 32'(MAX_PATTERN)) begin
            return USED_W'(MAX_PATTERN);
        end
        return USED_W'(w);
    endfunction

endpackage

`default_nettype wire

FILE: sv/epms_if.sv
// Stream interfaces for the pattern matcher: input words and result words.
// Depends on epms_pkg.
`default_nettype none

interface epms_in_if
    import epms_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [SYMBOL_W-1:0] symbol;

    modport source (output valid, output op, output symbol, input ready);
    modport sink   (input valid, input op, input symbol, output ready);
endinterface

interface epms_out_if
    import epms_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     match;
    logic [MATCH_START_W-1:0] match_start;

    modport source (output valid, output match, output match_start, input ready);
    modport sink   (input valid, input match, input match_start, output ready);
endinterface

`default_nettype wire

FILE: sv/exact_pattern_match_stream_top.sv
// Streaming exact pattern matcher, overlapping matches included.
// Input channel i_in carries words {op, symbol}: op load writes the next
// pattern byte (ignored once the store is full), op text shifts a byte
// into the window, op restart zeroes the text position, the window and
// the pattern fill count. Only text words give a result word on o_out:
// match, and match_start, the position of the first byte of the match
// (zero when there is no match). i_cfg_we / i_cfg_data set the pattern
// length; zero counts as one and values above the store depth saturate.
// Throughput is one word per cycle while the output queue has room: the
// window is a row of cells that shift every text word and compare against
// a pre-aligned pattern copy. Each result is registered in the output queue.
// A two-entry output queue takes results; while the receiver stalls the
// block keeps accepting until both entries hold results, then holds
// i_in.ready low. Reset (synchronous) empties the window and queue, sets
// position and fill to zero and length to one; the pattern store keeps
// no reset value and must be loaded before it is compared.
// Depends on epms_pkg, epms_if, epms_cell, epms_pattern and epms_outq.
`default_nettype none

module exact_pattern_match_stream_top
    import epms_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    epms_in_if.sink                   i_in,
    epms_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_LEN_W-1:0] i_cfg_data
);

    logic [CFG_LEN_W-1:0]     r_len;
    logic [CFG_LEN_W-1:0]     n_len;
    logic [POSITION_BITS-1:0] r_pos;
    logic [USED_W-1:0]        used;
    logic [PAT_BITS-1:0]      aligned;
    logic                     full;
    logic                     accept;
    logic                     is_load;
    logic                     is_text;
    logic                     is_restart;
    t_cell_ctrl               ctrl;
    logic [SYMBOL_W-1:0]      chain_sym [MAX_PATTERN+1];
    logic                     chain_vld [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0]   ok;
    logic                     hit;
    logic [POSITION_BITS-1:0] start;
    t_result                  res;
    t_result                  out_data;

    // No word is taken while reset is held.
    assign i_in.ready = i_rst_n && !full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        is_load    = 1'b0;
        is_text    = 1'b0;
        is_restart = 1'b0;
        case (i_in.op)
            OP_LOAD:    is_load    = accept;
            OP_TEXT:    is_text    = accept;
            OP_RESTART: is_restart = accept;
            default:    ;
        endcase
    end

    assign n_len = !i_rst_n ? LEN_RESET : (i_cfg_we ? i_cfg_data : r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
            r_pos <= '0;
        end else begin
            r_len <= n_len;
            if (is_restart) begin
                r_pos <= '0;
            end else if (is_text) begin
                r_pos <= r_pos + POSITION_BITS'(1);
            end
        end
    end

    assign used = f_used_len(r_len);

    epms_pattern u_pattern (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (is_load),
        .i_clear    (is_restart),
        .i_sym      (i_in.symbol),
        .i_len_next (f_used_len(n_len)),
        .o_aligned  (aligned)
    );

    assign ctrl.shift   = is_text;
    assign ctrl.clear   = is_restart;
    assign chain_sym[0] = i_in.symbol;
    assign chain_vld[0] = 1'b1;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        epms_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_sym   (chain_sym[k]),
            .i_vld   (chain_vld[k]),
            .i_pat   (aligned[k*SYMBOL_W +: SYMBOL_W]),
            .i_used  (USED_W'(k) < used),
            .o_sym   (chain_sym[k+1]),
            .o_vld   (chain_vld[k+1]),
            .o_ok    (ok[k])
        );
    end

    assign hit   = &ok;
    assign start = r_pos - POSITION_BITS'(used - USED_W'(1));

    always_comb begin
        res.match       = hit;
        res.match_start = hit ? MATCH_START_W'(start) : '0;
    end

    epms_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (is_text),
        .i_data  (res),
        .i_pop   (o_out.ready),
        .o_full  (full),
        .o_valid (o_out.valid),
        .o_data  (out_data)
    );

    assign o_out.match       = out_data.match;
    assign o_out.match_start = out_data.match_start;

endmodule

`default_nettype wire

FILE: sv/epms_cell.sv
// One window cell: holds one text byte and its valid flag, passes them on,
// and compares the incoming byte with its aligned pattern byte.
// Depends on epms_pkg.
`default_nettype none

module epms_cell
    import epms_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cell_ctrl          i_ctrl,
    input  wire logic [SYMBOL_W-1:0] i_sym,
    input  wire logic                i_vld,
    input  wire logic [SYMBOL_W-1:0] i_pat,
    input  wire logic                i_used,
    output logic      [SYMBOL_W-1:0] o_sym,
    output logic                     o_vld,
    output logic                     o_ok
);

    logic [SYMBOL_W-1:0] r_sym;
    logic                r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_sym <= i_sym;
        end
    end

    // The comparison looks at the byte this cell holds after the shift.
    assign o_ok  = !i_used || (i_vld && (i_sym == i_pat));
    assign o_sym = r_sym;
    assign o_vld = r_vld;

endmodule

`default_nettype wire

FILE: sv/epms_pattern.sv
// Pattern store with fill counter and the aligner that lines the pattern
// up with the window cells for the current length. Depends on epms_pkg.
`default_nettype none

module epms_pattern
    import epms_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr,
    input  wire logic                i_clear,
    input  wire logic [SYMBOL_W-1:0] i_sym,
    input  wire logic [USED_W-1:0]   i_len_next,
    output logic      [PAT_BITS-1:0] o_aligned
);

    logic [SYMBOL_W-1:0] r_pat [MAX_PATTERN];
    logic [SYMBOL_W-1:0] n_pat [MAX_PATTERN];
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;
    logic [PAT_BITS-1:0] r_aligned;
    logic [PAT_BITS-1:0] n_aligned;
    logic [PAT_BITS-1:0] rev;
    logic [USED_W-1:0]   shamt;
    logic                can_wr;

    assign can_wr = i_wr && (r_fill < FILL_W'(MAX_PATTERN));

    always_comb begin
        n_fill = r_fill;
        if (i_clear) begin
            n_fill = '0;
        end else if (can_wr) begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            n_pat[j] = r_pat[j];
            if (can_wr && (r_fill[IDX_W-1:0] == IDX_W'(j))) begin
                n_pat[j] = i_sym;
            end
        end
    end

    // Cell k needs pattern byte len-1-k: reverse the pattern, then shift
    // it down by the unused entries.
    always_comb begin
        for (int m = 0; m < MAX_PATTERN; m++) begin
            rev[m*SYMBOL_W +: SYMBOL_W] = n_pat[MAX_PATTERN-1-m];
        end
        shamt     = USED_W'(MAX_PATTERN) - i_len_next;
        n_aligned = rev >> (shamt * SYMBOL_W);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_aligned <= n_aligned;
        if (can_wr) begin
            r_pat <= n_pat;
        end
    end

    assign o_aligned = r_aligned;

endmodule

`default_nettype wire

FILE: sv/epms_outq.sv
// Two-entry output queue for result words; lets the input side keep
// going while one result waits. Depends on epms_pkg.
`default_nettype none

module epms_outq
    import epms_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_pop,
    output logic         o_full,
    output logic         o_valid,
    output t_result      o_data
);

    t_result    r_q0;
    t_result    r_q1;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;

    assign pop = i_pop && (r_cnt != 2'd0);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_cnt == 2'd2) begin
                r_q0 <= r_q1;
            end else if (i_push) begin
                r_q0 <= i_data;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= i_data;
            end else begin
                r_q1 <= i_data;
            end
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q0;

endmodule

`default_nettype wire
